FILE: src/tcpf_pkg.sv
// tcpf_pkg: fixed-point constants and series divisors shared by the field generator
package tcpf_pkg;

    localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [29:0] LN2_Q30     = 30'd744261118;

    localparam int SERIES_COS = 0;
    localparam int SERIES_EXP = 1;
    localparam int COS_STEPS  = 6;
    localparam int EXP_STEPS  = 12;

    // Divisor of Horner step 'step': cosine uses (2k)(2k-1) from the x^14 term down,
    // exponential uses k from 12 down to 1.
    function automatic int series_div(input int series, input int step);
        int d;
        d = 1;
        case (series)
            SERIES_COS:
            begin
                case (step)
                    0:       d = 182;
                    1:       d = 132;
                    2:       d = 90;
                    3:       d = 56;
                    4:       d = 30;
                    default: d = 12;
                endcase
            end
            default:
            begin
                d = EXP_STEPS - step;
            end
        endcase
        return d;
    endfunction

endpackage

FILE: src/tcpf_horner.sv
// tcpf_horner: pipelined Horner series b = 1 - (x*b)/d, three register stages per term
module tcpf_horner #(
    parameter int STEPS  = 6,
    parameter int SERIES = 0,
    parameter int TAG_W  = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [31:0]      in_x,
    input  logic [TAG_W-1:0] in_tag,
    output logic             out_valid,
    output logic [30:0]      out_b,
    output logic [31:0]      out_x,
    output logic [TAG_W-1:0] out_tag
);
    import tcpf_pkg::*;

    logic             vld_s [STEPS+1];
    logic [31:0]      x_s   [STEPS+1];
    logic [30:0]      b_s   [STEPS+1];
    logic [TAG_W-1:0] tag_s [STEPS+1];

    assign vld_s[0] = in_valid;
    assign x_s[0]   = in_x;
    assign b_s[0]   = ONE_Q30;
    assign tag_s[0] = in_tag;

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        localparam int          DIV   = series_div(SERIES, i);
        localparam logic [32:0] RECIP = 33'((64'd1 << 32) / DIV);

        logic             va_reg, vb_reg, vc_reg;
        logic [31:0]      xa_reg, xb_reg, xc_reg;
        logic [TAG_W-1:0] ta_reg, tb_reg, tc_reg;
        logic [31:0]      pa_reg;
        logic [31:0]      vb_val_reg;
        logic [31:0]      qb_reg;
        logic [30:0]      bc_reg;
        logic [62:0]      prod_a;
        logic [64:0]      prod_b;
        logic [39:0]      rem_c;
        logic [31:0]      quo_c;

        always_comb
        begin
            prod_a = 63'(x_s[i]) * 63'(b_s[i]);
            prod_b = 65'(pa_reg) * 65'(RECIP);
            // reciprocal estimate is low by at most one
            rem_c  = 40'(vb_val_reg) - 40'(qb_reg) * 40'(DIV);
            quo_c  = qb_reg;
            if (rem_c >= 40'(DIV))
            begin
                quo_c = qb_reg + 32'd1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                va_reg <= 1'b0;
                vb_reg <= 1'b0;
                vc_reg <= 1'b0;
            end
            else
            begin
                va_reg <= vld_s[i];
                vb_reg <= va_reg;
                vc_reg <= vb_reg;
            end
        end

        always_ff @(posedge clk)
        begin
            pa_reg     <= prod_a[61:30];
            xa_reg     <= x_s[i];
            ta_reg     <= tag_s[i];
            qb_reg     <= prod_b[63:32];
            vb_val_reg <= pa_reg;
            xb_reg     <= xa_reg;
            tb_reg     <= ta_reg;
            bc_reg     <= ONE_Q30 - quo_c[30:0];
            xc_reg     <= xb_reg;
            tc_reg     <= tb_reg;
        end

        assign vld_s[i+1] = vc_reg;
        assign x_s[i+1]   = xc_reg;
        assign b_s[i+1]   = bc_reg;
        assign tag_s[i+1] = tc_reg;
    end

    assign out_valid = vld_s[STEPS];
    assign out_b     = b_s[STEPS];
    assign out_x     = x_s[STEPS];
    assign out_tag   = tag_s[STEPS];

endmodule

FILE: src/two_color_pulse_field_generator.sv
// two_color_pulse_field_generator: pipelined two-color pulse field evaluator
//
// Usage: pulse start for one cycle with sample_time (Q16.16) to issue one sample.
// busy is tied low: a new sample may be issued every cycle, back to back.
// Each sample produces exactly one result beat, field_value (Q8.24, saturated) and
// saturated, shown for one cycle with done high.
// Results leave in issue order; the receiver cannot hold them off.
// Throughput is one sample per cycle; the deepest path is the exponential envelope
// chain: 12 series terms at three stages each (multiply, reciprocal multiply,
// correction), plus front-end, range reduction and output stages.
// Cosine lanes (carrier, second harmonic, sine-squared envelope) run shorter and
// are delayed to line up with the envelope. Registers are written through
// cfg_we/cfg_index/cfg_data, by the user only while no sample is in flight; the
// block does not enforce this. Reset clears the pipeline valid bits and loads
// register defaults (pulse length and its inverse 1.0, everything else 0).
module two_color_pulse_field_generator #(
    parameter int ANGLE_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] sample_time,
    output logic        done,
    output logic [31:0] field_value,
    output logic        saturated,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import tcpf_pkg::*;

    localparam int AB = ANGLE_BITS;
    localparam int QB = ANGLE_BITS - 2;

    localparam logic [2:0] REG_AMPLITUDE    = 3'd0;
    localparam logic [2:0] REG_SECOND_RATIO = 3'd1;
    localparam logic [2:0] REG_CARRIER_RATE = 3'd2;
    localparam logic [2:0] REG_SECOND_PHASE = 3'd3;
    localparam logic [2:0] REG_PULSE_LENGTH = 3'd4;
    localparam logic [2:0] REG_PULSE_INV    = 3'd5;
    localparam logic [2:0] REG_PULSE_CENTER = 3'd6;
    localparam logic [2:0] REG_ENV_MODE     = 3'd7;

    localparam logic MODE_SINE = 1'b1;

    localparam logic [10:0] LN2_RECIP = 11'((64'd1 << 40) / 64'(LN2_Q30));
    localparam int COS_LAT = 3 + 3 * COS_STEPS + 2;
    localparam int EXP_LAT = 2 + 3 * EXP_STEPS + 1;
    localparam int ALIGN   = EXP_LAT - COS_LAT;
    localparam int TAG_W   = 9;

    // ---------------- configuration registers
    logic [31:0] amplitude_reg;
    logic [15:0] second_ratio_reg;
    logic [31:0] carrier_rate_reg;
    logic [15:0] second_phase_reg;
    logic [30:0] pulse_length_reg;
    logic [31:0] pulse_length_inverse_reg;
    logic [31:0] pulse_center_reg;
    logic        envelope_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amplitude_reg            <= 32'd0;
            second_ratio_reg         <= 16'd0;
            carrier_rate_reg         <= 32'd0;
            second_phase_reg         <= 16'd0;
            pulse_length_reg         <= 31'd65536;
            pulse_length_inverse_reg <= 32'd65536;
            pulse_center_reg         <= 32'd0;
            envelope_mode_reg        <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_AMPLITUDE:    amplitude_reg            <= cfg_data;
                REG_SECOND_RATIO: second_ratio_reg         <= cfg_data[15:0];
                REG_CARRIER_RATE: carrier_rate_reg         <= cfg_data;
                REG_SECOND_PHASE: second_phase_reg         <= cfg_data[15:0];
                REG_PULSE_LENGTH: pulse_length_reg         <= cfg_data[30:0];
                REG_PULSE_INV:    pulse_length_inverse_reg <= cfg_data;
                REG_PULSE_CENTER: pulse_center_reg         <= cfg_data;
                REG_ENV_MODE:     envelope_mode_reg        <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    logic sine_mode;
    assign sine_mode = (envelope_mode_reg == MODE_SINE);
    assign busy = 1'b0;

    // ---------------- front end
    logic        v1_reg, v2_reg, v3_reg, v4_reg;
    logic [31:0] t_reg;

    logic signed [32:0] dt2, pd2;
    logic [32:0]        mag2;
    logic               zero2;
    logic signed [32:0] pd2_reg;
    logic [32:0]        mag2_reg;
    logic [30:0]        tw2_reg;
    logic               zero2_reg;

    always_comb
    begin
        dt2   = 33'($signed(t_reg)) - 33'($signed(pulse_center_reg));
        mag2  = dt2[32] ? 33'(-dt2) : 33'(dt2);
        pd2   = sine_mode ? ($signed({t_reg, 1'b0}) - $signed({2'b00, pulse_length_reg}))
                          : dt2;
        zero2 = sine_mode && (t_reg[31] ||
                ($signed({t_reg[31], t_reg}) > $signed({2'b00, pulse_length_reg})));
    end

    logic [64:0]        u3;
    logic signed [65:0] cp3;
    logic [62:0]        ap3;
    logic [AB-1:0]      a1_3, a2_3;
    logic [AB-1:0]      a1_3_reg, a2_3_reg, aenv_3_reg;
    logic [26:0]        u24_3_reg;
    logic               gz3_reg, zero3_reg;

    always_comb
    begin
        u3  = 65'(mag2_reg) * 65'(pulse_length_inverse_reg);
        cp3 = 66'(pd2_reg) * $signed({34'd0, carrier_rate_reg});
        ap3 = 63'(tw2_reg) * 63'(pulse_length_inverse_reg);
        if (sine_mode)
        begin
            a1_3 = cp3[45-AB +: AB];
            a2_3 = cp3[44-AB +: AB];
        end
        else
        begin
            a1_3 = cp3[44-AB +: AB];
            a2_3 = cp3[43-AB +: AB];
        end
    end

    logic [39:0]   ph_full;
    logic [53:0]   usq4;
    logic [AB-1:0] ang_reg [3];
    logic [35:0]   s4_reg;
    logic          gz4_reg, zero4_reg;

    assign ph_full = {second_phase_reg, 24'd0} >> (40 - AB);
    assign usq4    = 54'(u24_3_reg) * 54'(u24_3_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg      <= sample_time;
        pd2_reg    <= pd2;
        mag2_reg   <= mag2;
        tw2_reg    <= t_reg[30:0];
        zero2_reg  <= zero2;
        a1_3_reg   <= a1_3;
        a2_3_reg   <= a2_3;
        aenv_3_reg <= ap3[32-AB +: AB];
        u24_3_reg  <= u3[34:8];
        gz3_reg    <= (u3[64:32] >= 33'd5);
        zero3_reg  <= zero2_reg;
        ang_reg[0] <= a1_3_reg;
        ang_reg[1] <= a2_3_reg + ph_full[AB-1:0];
        ang_reg[2] <= aenv_3_reg;
        s4_reg     <= usq4[53:18];
        gz4_reg    <= gz3_reg;
        zero4_reg  <= zero3_reg;
    end

    // ---------------- cosine lanes: carrier, second harmonic, sine-squared envelope
    logic [31:0] cos_al [3];

    for (genvar l = 0; l < 3; l++) begin : g_cos
        localparam logic [QB:0] QUAD = {1'b1, {QB{1'b0}}};

        logic [QB:0]        rf;
        logic [QB:0]        rf_reg;
        logic               fn_reg, xn_reg, x2n_reg, pn_reg;
        logic [QB+31:0]     xp;
        logic [30:0]        x_reg;
        logic [61:0]        x2p;
        logic [31:0]        x2_reg;
        logic [30:0]        hb;
        logic [31:0]        hx;
        logic [0:0]         htag;
        logic [62:0]        pp;
        logic [31:0]        pp_reg;
        logic signed [32:0] cd;
        logic [30:0]        cmag;
        logic [31:0]        c_reg;
        logic [31:0]        dl_reg [ALIGN];

        always_comb
        begin
            // odd quadrants mirror the remainder; quadrants 1 and 2 are negative
            rf   = ang_reg[l][AB-2] ? (QUAD - {1'b0, ang_reg[l][QB-1:0]})
                                    : {1'b0, ang_reg[l][QB-1:0]};
            xp   = (QB+32)'(rf_reg) * (QB+32)'(HALF_PI_Q30);
            x2p  = 62'(x_reg) * 62'(x_reg);
            pp   = 63'(hx) * 63'(hb);
            cd   = $signed({2'b00, ONE_Q30}) - $signed({1'b0, pp_reg});
            cmag = cd[32] ? 31'd0 : cd[30:0];
        end

        tcpf_horner #(
            .STEPS (COS_STEPS),
            .SERIES(SERIES_COS),
            .TAG_W (1)
        ) u_series (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (v4_reg),
            .in_x     (x2_reg),
            .in_tag   (x2n_reg),
            .out_valid(),
            .out_b    (hb),
            .out_x    (hx),
            .out_tag  (htag)
        );

        always_ff @(posedge clk)
        begin
            rf_reg  <= rf;
            fn_reg  <= ang_reg[l][AB-1] ^ ang_reg[l][AB-2];
            x_reg   <= xp[QB+30:QB];
            xn_reg  <= fn_reg;
            x2_reg  <= x2p[61:30];
            x2n_reg <= xn_reg;
            pp_reg  <= pp[62:31];
            pn_reg  <= htag[0];
            c_reg   <= pn_reg ? (32'd0 - 32'(cmag)) : 32'(cmag);
            dl_reg[0] <= c_reg;
            for (int k = 1; k < ALIGN; k++)
            begin
                dl_reg[k] <= dl_reg[k-1];
            end
        end

        assign cos_al[l] = dl_reg[ALIGN-1];
    end

    // ---------------- gaussian envelope: exp(-s) = exp(-f) >> n
    logic [46:0]       np5;
    logic [6:0]        n5_reg;
    logic [35:0]       s5_reg;
    logic              v5_reg, gz5_reg, zero5_reg;
    logic [36:0]       r6;
    logic [6:0]        n6;
    logic [29:0]       f6;
    logic [6:0]        n6_reg;
    logic [29:0]       f6_reg;
    logic              v6_reg, gz6_reg, zero6_reg;
    logic              hv;
    logic [30:0]       hb_e;
    logic [31:0]       hx_e;
    logic [TAG_W-1:0]  htag_e;
    logic [30:0]       envg_reg;
    logic              ve_reg, zeroe_reg;

    always_comb
    begin
        np5 = 47'(s4_reg) * 47'(LN2_RECIP);
        r6  = 37'(s5_reg) - 37'(n5_reg) * 37'(LN2_Q30);
        n6  = n5_reg;
        f6  = r6[29:0];
        if (r6 >= 37'(LN2_Q30))
        begin
            n6 = n5_reg + 7'd1;
            f6 = 30'(r6 - 37'(LN2_Q30));
        end
    end

    tcpf_horner #(
        .STEPS (EXP_STEPS),
        .SERIES(SERIES_EXP),
        .TAG_W (TAG_W)
    ) u_exp_series (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (v6_reg),
        .in_x     ({2'b00, f6_reg}),
        .in_tag   ({n6_reg, gz6_reg, zero6_reg}),
        .out_valid(hv),
        .out_b    (hb_e),
        .out_x    (hx_e),
        .out_tag  (htag_e)
    );

    // ---------------- combine and scale
    logic               v_f1_reg, v_f2_reg, v_f3_reg, v_f4_reg;
    logic               z_f1_reg, z_f2_reg, z_f3_reg, z_f4_reg;
    logic signed [32:0] ediff;
    logic [30:0]        env_f1_reg, env_f2_reg;
    logic signed [47:0] alpha_f1_reg;
    logic [31:0]        c1_f1_reg;
    logic signed [36:0] fill;
    logic [35:0]        mf;
    logic [35:0]        mf_f2_reg;
    logic               neg_f2_reg, neg_f3_reg, neg_f4_reg;
    logic [66:0]        gp;
    logic [36:0]        gm_f3_reg;
    logic [31:0]        am;
    logic [64:0]        pmp;
    logic [38:0]        pm_f4_reg;
    logic               sat_o;
    logic [31:0]        val_o;
    logic               done_reg, saturated_reg;
    logic [31:0]        field_value_reg;

    always_comb
    begin
        ediff = $signed({2'b00, ONE_Q30}) - 33'($signed(cos_al[2]));
        fill  = 37'($signed(c1_f1_reg)) + 37'(alpha_f1_reg >>> 12);
        mf    = fill[36] ? 36'(-fill) : 36'(fill);
        gp    = 67'(mf_f2_reg) * 67'(env_f2_reg);
        am    = amplitude_reg[31] ? (32'd0 - amplitude_reg) : amplitude_reg;
        pmp   = 65'(am) * 65'(gm_f3_reg[36:4]);
        if (neg_f4_reg)
        begin
            sat_o = (pm_f4_reg > 39'h00_8000_0000);
            val_o = sat_o ? 32'h8000_0000 : (32'd0 - pm_f4_reg[31:0]);
        end
        else
        begin
            sat_o = (pm_f4_reg > 39'h00_7FFF_FFFF);
            val_o = sat_o ? 32'h7FFF_FFFF : pm_f4_reg[31:0];
        end
        // sine-squared mode outside the pulse window
        if (z_f4_reg)
        begin
            sat_o = 1'b0;
            val_o = 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg   <= 1'b0;
            v6_reg   <= 1'b0;
            ve_reg   <= 1'b0;
            v_f1_reg <= 1'b0;
            v_f2_reg <= 1'b0;
            v_f3_reg <= 1'b0;
            v_f4_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v5_reg   <= v4_reg;
            v6_reg   <= v5_reg;
            ve_reg   <= hv;
            v_f1_reg <= ve_reg;
            v_f2_reg <= v_f1_reg;
            v_f3_reg <= v_f2_reg;
            v_f4_reg <= v_f3_reg;
            done_reg <= v_f4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        n5_reg    <= np5[46:40];
        s5_reg    <= s4_reg;
        gz5_reg   <= gz4_reg;
        zero5_reg <= zero4_reg;
        n6_reg    <= n6;
        f6_reg    <= f6;
        gz6_reg   <= gz5_reg;
        zero6_reg <= zero5_reg;
        // tag: n in [8:2], envelope cut-off in [1], window miss in [0]
        envg_reg  <= htag_e[1] ? 31'd0 : (hb_e >> htag_e[8:2]);
        zeroe_reg <= htag_e[0] | (hx_e[31:30] != 2'b00);

        env_f1_reg   <= sine_mode ? ediff[31:1] : envg_reg;
        alpha_f1_reg <= $signed(second_ratio_reg) * $signed(cos_al[1]);
        c1_f1_reg    <= cos_al[0];
        z_f1_reg     <= zeroe_reg;

        mf_f2_reg  <= mf;
        neg_f2_reg <= fill[36];
        env_f2_reg <= env_f1_reg;
        z_f2_reg   <= z_f1_reg;

        gm_f3_reg  <= gp[66:30];
        neg_f3_reg <= neg_f2_reg;
        z_f3_reg   <= z_f2_reg;

        pm_f4_reg  <= pmp[64:26];
        neg_f4_reg <= neg_f3_reg ^ amplitude_reg[31];
        z_f4_reg   <= z_f3_reg;

        field_value_reg <= val_o;
        saturated_reg   <= sat_o;
    end

    assign done        = done_reg;
    assign field_value = field_value_reg;
    assign saturated   = saturated_reg;

endmodule

FILE: sim/testbench.sv
// testbench: self-checking bench for the two-color pulse field generator
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int AB = 16;
    localparam longint unsigned MASK = (64'd1 << AB) - 1;
    localparam longint unsigned QTR = 64'd1 << (AB - 2);
    localparam longint unsigned Q30 = 64'd1 << 30;
    localparam longint unsigned HPI = 64'd1686629713;
    localparam longint unsigned LN2 = 64'd744261118;
    localparam int WD_LIMIT = 3000;
    localparam int NPHASE = 9;
    localparam int PER_PHASE = 72;

    typedef enum logic [2:0] {
        R_AMP, R_RATIO, R_RATE, R_PHASE, R_PLEN, R_PINV, R_PCTR, R_MODE
    } reg_idx_t;

    typedef struct {
        bit          typed;
        logic [31:0] val;
        logic        sat;
    } field_t;

    typedef struct {
        int          cset;
        logic [31:0] t;
        bit          typed;
        logic [31:0] val;
        logic        sat;
    } row_t;

    logic        clk, rst_n, start, busy, done, saturated, cfg_we;
    logic [31:0] sample_time, field_value, cfg_data;
    logic [2:0]  cfg_index;

    // local copy of the register file
    logic [31:0] amp_r, rate_r, pinv_r, pctr_r;
    logic [15:0] ratio_r, phase_r;
    logic [30:0] plen_r;
    logic        mode_r;

    field_t      typed_q[$];
    field_t      field_q[$];
    int          errors;
    int          idle_cycles;
    int          send_idle_pct;
    bit          timed_out;

    two_color_pulse_field_generator uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .sample_time(sample_time), .done(done), .field_value(field_value),
        .saturated(saturated), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint quad_cos(longint unsigned r);
        longint unsigned den[6] = '{182, 132, 90, 56, 30, 12};
        longint unsigned x, x2, b;
        longint c;
        x = (r * HPI) >> (AB - 2);
        x2 = (x * x) >> 30;
        b = Q30;
        for (int i = 0; i < 6; i++)
            b = Q30 - ((x2 * b) >> 30) / den[i];
        c = longint'(Q30) - longint'((x2 * b) >> 31);
        return (c < 0) ? 0 : c;
    endfunction

    function automatic longint cos_turns(longint unsigned a);
        longint unsigned r;
        r = a & (QTR - 1);
        case ((a >> (AB - 2)) & 3)
            0: return quad_cos(r);
            1: return -quad_cos(QTR - r);
            2: return -quad_cos(r);
            default: return quad_cos(QTR - r);
        endcase
    endfunction

    function automatic longint exp_decay(longint unsigned s);
        longint unsigned n, f, b;
        n = s / LN2;
        f = s - n * LN2;
        b = Q30;
        if (n > 40)
            return 0;
        for (int k = 12; k >= 1; k--)
            b = Q30 - ((f * b) >> 30) / longint'(k);
        return longint'(b >> n);
    endfunction

    function automatic field_t field_at(logic [31:0] ts);
        field_t          res;
        longint          t, dt, env, fill, amp;
        longint unsigned mag, u, u24, prod, a1, a2, mf, gm, am, pm;
        int              fb;
        bit              neg;
        res.typed = 1'b0;
        res.sat = 1'b0;
        t = longint'(signed'(ts));
        if (!mode_r)
        begin
            dt = t - longint'(signed'(pctr_r));
            mag = (dt < 0) ? longint'(-dt) : dt;
            u = mag * {32'd0, pinv_r};
            if (u >= (64'd5 << 32))
                env = 0;
            else
            begin
                u24 = u >> 8;
                env = exp_decay((u24 * u24) >> 18);
            end
            prod = longint'(dt) * {32'd0, rate_r};
            fb = 44;
        end
        else
        begin
            if (t < 0 || t > longint'({33'd0, plen_r}))
            begin
                res.val = 32'd0;
                return res;
            end
            a1 = ((longint'(t) * {32'd0, pinv_r}) >> (32 - AB)) & MASK;
            env = (longint'(Q30) - cos_turns(a1)) >>> 1;
            prod = longint'(2 * t - longint'({33'd0, plen_r})) * {32'd0, rate_r};
            fb = 45;
        end
        a1 = (prod >> (fb - AB)) & MASK;
        a2 = ((prod << 1) >> (fb - AB)) & MASK;
        a2 = (a2 + ((longint'(phase_r) << 24) >> (40 - AB))) & MASK;
        fill = cos_turns(a1) + ((longint'(signed'(ratio_r)) * cos_turns(a2)) >>> 12);
        neg = fill < 0;
        mf = neg ? longint'(-fill) : fill;
        gm = (mf * longint'(env)) >> 30;
        amp = longint'(signed'(amp_r));
        if (amp < 0)
        begin
            neg = !neg;
            am = -amp;
        end
        else
            am = amp;
        pm = (am * (gm >> 4)) >> 26;
        if (neg)
        begin
            if (pm > 64'h8000_0000)
            begin
                pm = 64'h8000_0000;
                res.sat = 1'b1;
            end
            res.val = 32'd0 - pm[31:0];
        end
        else
        begin
            if (pm > 64'h7FFF_FFFF)
            begin
                pm = 64'h7FFF_FFFF;
                res.sat = 1'b1;
            end
            res.val = pm[31:0];
        end
        return res;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch %s: got %h want %h", what, got, want);
    endtask

    // accept side: predict on each start beat, check on each done beat
    always @(posedge clk)
    begin
        field_t e, ty;
        bit     acc;
        if (rst_n)
        begin
            acc = 1'b0;
            if (start && !busy)
            begin
                acc = 1'b1;
                e = field_at(sample_time);
                ty = typed_q.pop_front();
                if (ty.typed)
                    e = ty;
                field_q.push_back(e);
            end
            if (done)
            begin
                acc = 1'b1;
                if (field_q.size() == 0)
                    report("unexpected beat", field_value, 32'd0);
                else
                begin
                    e = field_q.pop_front();
                    if (field_value !== e.val)
                        report("field_value", field_value, e.val);
                    if (saturated !== e.sat)
                        report("saturated", {31'd0, saturated}, {31'd0, e.sat});
                end
            end
            idle_cycles <= acc ? 0 : idle_cycles + 1;
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [31:0] d);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        case (idx)
            R_AMP:   amp_r = d;
            R_RATIO: ratio_r = d[15:0];
            R_RATE:  rate_r = d;
            R_PHASE: phase_r = d[15:0];
            R_PLEN:  plen_r = d[30:0];
            R_PINV:  pinv_r = d;
            R_PCTR:  pctr_r = d;
            default: mode_r = d[0];
        endcase
    endtask

    // stop sending and let the last beat reach the scoreboard before waiting
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (field_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic load_regs(logic [31:0] v[8]);
        drain();
        for (int i = 0; i < 8; i++)
            write_reg(reg_idx_t'(i), v[i]);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // called just after a rising edge; start stays high into the next call
    task automatic issue(logic [31:0] t, field_t ty);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        sample_time <= t;
        typed_q.push_back(ty);
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    function automatic logic [31:0] pick32();
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(32'h0200_0000);
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        logic [31:0] cfgs[6][8];
        logic [31:0] v[8];
        row_t        rows[$];
        field_t      ty;
        logic [31:0] t, tp;
        int          cur;
        rst_n = 1'b0;
        start = 1'b0;
        sample_time = '0;
        cfg_we = 1'b0;
        cfg_index = R_AMP;
        cfg_data = '0;
        errors = 0;
        idle_cycles = 0;
        send_idle_pct = 0;
        timed_out = 1'b0;
        amp_r = 0; ratio_r = 0; rate_r = 0; phase_r = 0;
        plen_r = 31'h10000; pinv_r = 32'h10000; pctr_r = 0; mode_r = 0;

        // set 0 is the reset state and is never written
        cfgs[1] = '{32'h7FFF_FFFF, 32'h7FFF, 0, 0, 32'h10000, 32'h10000, 0, 0};
        cfgs[2] = '{32'h8000_0000, 32'h7FFF, 0, 0, 32'h10000, 32'h10000, 0, 0};
        cfgs[3] = '{32'h0100_0000, 32'hABCD_8000, 32'hFFFF_FFFF, 32'h1234_FFFF,
                    32'h20000, 32'h8000, 32'h1234, 32'hFFFF_FFFF};
        cfgs[4] = '{32'h0100_0000, 32'h1000, 32'h1000_0000, 32'h4000,
                    32'h7FFF_FFFF, 0, 32'h8000_0000, 0};
        cfgs[5] = '{32'h0100_0000, 32'h1000, 32'h1000_0000, 32'h4000,
                    32'h0004_0000, 0, 0, 1};
        rows = '{
            '{0, 32'h0000_0000, 1, 32'h0, 0},
            '{0, 32'h7FFF_FFFF, 1, 32'h0, 0},
            '{0, 32'h8000_0000, 1, 32'h0, 0},
            '{1, 32'h0000_0000, 1, 32'h7FFF_FFFF, 1},
            '{1, 32'h0000_8000, 0, 0, 0},
            '{1, 32'h7FFF_FFFF, 0, 0, 0},
            '{1, 32'h8000_0000, 0, 0, 0},
            '{2, 32'h0000_0000, 1, 32'h8000_0000, 1},
            '{2, 32'h0001_0000, 0, 0, 0},
            '{3, 32'hFFFF_FFFF, 1, 32'h0, 0},
            '{3, 32'h0002_0001, 1, 32'h0, 0},
            '{3, 32'h8000_0000, 1, 32'h0, 0},
            '{3, 32'h0000_0000, 0, 0, 0},
            '{3, 32'h0002_0000, 0, 0, 0},
            '{3, 32'h0001_0000, 0, 0, 0},
            '{4, 32'h0000_0000, 0, 0, 0},
            '{4, 32'h7FFF_FFFF, 0, 0, 0},
            '{4, 32'h8000_0000, 0, 0, 0},
            '{4, 32'h1234_5678, 0, 0, 0},
            '{5, 32'h0000_0100, 0, 0, 0},
            '{5, 32'h0000_0000, 0, 0, 0}
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        cur = 0;
        foreach (rows[i])
        begin
            if (rows[i].cset != cur)
            begin
                cur = rows[i].cset;
                load_regs(cfgs[cur]);
            end
            ty.typed = rows[i].typed;
            ty.val = rows[i].val;
            ty.sat = rows[i].sat;
            issue(rows[i].t, ty);
        end

        ty.typed = 1'b0;
        for (int ph = 0; ph < NPHASE; ph++)
        begin
            case (ph / 3)
                0: send_idle_pct = 20;
                1: send_idle_pct = 73;
                default: send_idle_pct = 0;
            endcase
            tp = $urandom_range(32'h0010_0000, 32'h0000_0100);
            if (ph == NPHASE - 1)
                tp = 32'h7FFF_FFFF;
            v[R_AMP] = pick32();
            v[R_RATIO] = $urandom;
            v[R_RATE] = ($urandom_range(3) == 0) ? pick32() : $urandom_range(32'h2000_0000);
            v[R_PHASE] = $urandom;
            v[R_PLEN] = {1'($urandom_range(1)), tp[30:0]};
            v[R_PINV] = ($urandom_range(7) == 0) ? $urandom : 32'hFFFF_FFFF / tp;
            v[R_PCTR] = $urandom;
            v[R_MODE] = {31'($urandom_range(32'h7FFF_FFFF)), ph[0]};
            load_regs(v);
            for (int i = 0; i < PER_PHASE; i++)
            begin
                // mostly samples near the envelope where the field is nonzero
                case ($urandom_range(3))
                    0: t = $urandom;
                    default:
                    begin
                        if (mode_r)
                            t = $urandom_range({1'b0, plen_r});
                        else
                            t = pctr_r + $urandom_range(2 * tp) - tp;
                    end
                endcase
                issue(t, ty);
            end
        end

        drain();
        repeat (60) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= WD_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("tb: failure");
            $finish;
        end
    end

endmodule
